// File: hdl/fbpa_pkg.sv
package fbpa_pkg;

   localparam int INDEX_W            = 10;
   localparam int COUNT_W            = 11;
   localparam int STATUS_W           = 2;
   localparam int DEFAULT_POOL_DEPTH = 1024;
   localparam int LIMIT_RESET        = 1024;
   localparam int REQ_DATA_W         = 16;
   localparam int RSP_DATA_W         = 24;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  granted_index;
      logic [COUNT_W-1:0]  blocks_used;
   } rsp_type;

endpackage

// File: hdl/fbpa_link_ram.sv
module fbpa_link_ram #(
   parameter int POOL_DEPTH = fbpa_pkg::DEFAULT_POOL_DEPTH,
   parameter int ADDR_W     = $clog2(POOL_DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [fbpa_pkg::INDEX_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [fbpa_pkg::INDEX_W-1:0] rd_data
);
   import fbpa_pkg::*;

   logic [INDEX_W-1:0] link_mem_ff [POOL_DEPTH];
   logic [INDEX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/fbpa_pool_core.sv
module fbpa_pool_core #(
   parameter int POOL_DEPTH = fbpa_pkg::DEFAULT_POOL_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [fbpa_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                         fire,
   input  fbpa_pkg::req_type            req,
   output fbpa_pkg::rsp_type            rsp
);
   import fbpa_pkg::*;

   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam logic [COUNT_W-1:0] LIMIT_INIT =
      COUNT_W'((POOL_DEPTH < LIMIT_RESET) ? POOL_DEPTH : LIMIT_RESET);
   localparam logic [COUNT_W-1:0] LIMIT_SAT = COUNT_W'(POOL_DEPTH);

   logic [COUNT_W-1:0] limit_ff;
   logic [INDEX_W-1:0] top_ff, top_in;
   logic [INDEX_W-1:0] next_ff, next_in;
   logic               pend_ff, pend_in;
   logic               nonempty_ff, nonempty_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [COUNT_W-1:0] used_ff, used_in;

   logic [INDEX_W-1:0] next_eff;
   logic [INDEX_W-1:0] rd_data;
   logic               pop, push;
   logic [COUNT_W-1:0] used_inc, used_dec;
   logic [COUNT_W-1:0] limit_wr;
   logic [ADDR_W+INDEX_W-1:0] wr_wide, rd_wide;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;

   // link of the current top: prefetched, or still in the RAM read register
   assign next_eff = pend_ff ? rd_data : next_ff;

   assign used_inc = (&used_ff) ? used_ff : used_ff + COUNT_W'(1);
   assign used_dec = (used_ff == '0) ? used_ff : used_ff - COUNT_W'(1);

   assign wr_wide = {{ADDR_W{1'b0}}, req.block_index};
   assign rd_wide = {{ADDR_W{1'b0}}, next_eff};
   assign wr_addr = wr_wide[ADDR_W-1:0];
   assign rd_addr = rd_wide[ADDR_W-1:0];

   always_comb begin
      pop         = 1'b0;
      push        = 1'b0;
      top_in      = top_ff;
      next_in     = next_ff;
      pend_in     = pend_ff;
      nonempty_in = nonempty_ff;
      fresh_in    = fresh_ff;
      used_in     = used_ff;
      rsp.status        = STATUS_OK;
      rsp.granted_index = '0;

      case (req.op)
         OP_ALLOC: begin
            if (nonempty_ff) begin
               pop               = 1'b1;
               rsp.granted_index = top_ff;
               top_in            = next_eff;
               pend_in           = 1'b1;
               used_in           = used_inc;
               nonempty_in       = fresh_ff > used_inc;
            end else if (fresh_ff < limit_ff) begin
               rsp.granted_index = fresh_ff[INDEX_W-1:0];
               fresh_in          = fresh_ff + COUNT_W'(1);
               used_in           = used_inc;
            end else begin
               rsp.status = STATUS_FULL;
            end
         end
         OP_FREE: begin
            if ({1'b0, req.block_index} >= limit_ff) begin
               rsp.status = STATUS_RANGE;
            end else begin
               push        = 1'b1;
               top_in      = req.block_index;
               next_in     = top_ff;
               pend_in     = 1'b0;
               nonempty_in = 1'b1;
               used_in     = used_dec;
            end
         end
         default: begin
            rsp.status = STATUS_FULL;
         end
      endcase
      rsp.blocks_used = used_in;
   end

   assign limit_wr = (32'(csr_wr_data) > POOL_DEPTH) ? LIMIT_SAT : csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_INIT;
         top_ff      <= '0;
         pend_ff     <= 1'b0;
         nonempty_ff <= 1'b0;
         fresh_ff    <= '0;
         used_ff     <= '0;
      end else if (csr_wr_en) begin
         limit_ff    <= limit_wr;
         top_ff      <= '0;
         pend_ff     <= 1'b0;
         nonempty_ff <= 1'b0;
         fresh_ff    <= '0;
         used_ff     <= '0;
      end else if (fire) begin
         top_ff      <= top_in;
         pend_ff     <= pend_in;
         nonempty_ff <= nonempty_in;
         fresh_ff    <= fresh_in;
         used_ff     <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         next_ff <= next_in;
      end
   end

   fbpa_link_ram #(
      .POOL_DEPTH (POOL_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (fire & push),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_en   (fire & pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// Each request passes the request register, then the response register.
// Throughput: one request per cycle while the response side is not stalled,
//   back-to-back allocations included; the link of the next stack top comes
//   from the link RAM's registered read port.
// Reset (synchronous): pool empty, block limit min(1024, POOL_DEPTH); link RAM
//   is not cleared. A CSR write also empties the pool, limit = min(data, POOL_DEPTH).
module fixed_block_pool_allocator #(
   parameter int POOL_DEPTH = fbpa_pkg::DEFAULT_POOL_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fbpa_pkg::COUNT_W-1:0]    csr_wr_data,   // block limit
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fbpa_pkg::REQ_DATA_W-1:0] req_tdata,     // [9:0] block_index
   input  logic                            req_tuser,     // [0] op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fbpa_pkg::RSP_DATA_W-1:0] rsp_tdata,     // [9:0] granted_index,
                                                          // [20:10] blocks_used
   output logic [fbpa_pkg::STATUS_W-1:0]   rsp_tuser      // [1:0] status
);
   import fbpa_pkg::*;

   logic    in_valid_ff;
   req_type in_req_ff, in_req_in;
   logic    out_valid_ff;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    fire;

   assign fire       = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | fire;

   assign in_req_in.op          = op_type'(req_tuser);
   assign in_req_in.block_index = req_tdata[INDEX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         in_req_ff <= in_req_in;
      end
      if (fire) begin
         out_rsp_ff <= core_rsp;
      end
   end

   fbpa_pool_core #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_pool_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .req         (in_req_ff),
      .rsp         (core_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W - INDEX_W){1'b0}},
                        out_rsp_ff.blocks_used, out_rsp_ff.granted_index};
   assign rsp_tuser  = out_rsp_ff.status;

endmodule
